/* design/ccft_pkg.sv */
package ccft_pkg;
   localparam int MaxPointsDefault = 1024;
   localparam int CoordBitsDefault = 12;
   localparam int FieldBits = CoordBitsDefault;
   localparam int LimitBits = 32;
   localparam int RadiusBits = 21;
   localparam logic [LimitBits-1:0] LimitReset = 32'd65536;

   typedef struct packed {
      logic [FieldBits-1:0] point_x;
      logic [FieldBits-1:0] point_y;
      logic                 last_point;
   } req_type;

   typedef struct packed {
      logic [FieldBits-1:0]  center_x;
      logic [FieldBits-1:0]  center_y;
      logic [RadiusBits-1:0] radius_fixed;
      logic                  is_circle;
      logic                  point_overflow;
   } rsp_type;

   // Operation codes for the shared divide / square-root unit.
   localparam logic OpDiv  = 1'b0;
   localparam logic OpSqrt = 1'b1;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [63:0] num;
      logic [31:0] den;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;
endpackage

/* design/ccft_req_if.sv */
interface ccft_req_if;
   logic             valid;
   logic             ready;
   ccft_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/ccft_rsp_if.sv */
interface ccft_rsp_if;
   logic             valid;
   logic             ready;
   ccft_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/contour_circle_fit_test.sv */
// Channel  Dir  Contents
// req      in   point_x, point_y, last_point
// rsp      out  center_x, center_y, radius_fixed, is_circle, point_overflow
// csr      in   mean_sq_dev_limit write
//
// A point without the last flag is written to the store if there is room, then the
// block passes a wait state and is ready again. A last point runs: 2 divides,
// then reads for the square sum, a divide and a root, then n passes (read, root,
// square, add), then a final divide.
// All divides and roots go through one shared divide/root unit, one bit per cycle.
// Reset is synchronous; the store needs no clearing. A result not yet taken holds
// the block only once the next result is ready to be sent.
module contour_circle_fit_test #(
   parameter int MAX_POINTS = ccft_pkg::MaxPointsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   ccft_req_if.sink                       req,
   ccft_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [ccft_pkg::LimitBits-1:0] csr_write_data
);
   import ccft_pkg::*;

   localparam int COORD_BITS = CoordBitsDefault;
   localparam int AddrBits  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CountBits = $clog2(MAX_POINTS + 1);
   localparam int SumBits   = COORD_BITS + CountBits;
   localparam logic [CountBits-1:0] CountMax = CountBits'(MAX_POINTS);

   localparam logic [3:0] StIdle    = 4'd0;
   localparam logic [3:0] StDivX    = 4'd1;
   localparam logic [3:0] StDivY    = 4'd2;
   localparam logic [3:0] StRead1   = 4'd3;
   localparam logic [3:0] StAcc1    = 4'd4;
   localparam logic [3:0] StMeanSq  = 4'd5;
   localparam logic [3:0] StRadius  = 4'd6;
   localparam logic [3:0] StRead2   = 4'd7;
   localparam logic [3:0] StDist    = 4'd8;
   localparam logic [3:0] StDev     = 4'd9;
   localparam logic [3:0] StMeanDev = 4'd10;
   localparam logic [3:0] StOut     = 4'd11;
   localparam logic [3:0] StWait    = 4'd12;
   localparam logic [3:0] StRead1b  = 4'd13;
   localparam logic [3:0] StRead2b  = 4'd14;
   localparam logic [3:0] StSq      = 4'd15;

   logic [2*COORD_BITS-1:0] store_mem [MAX_POINTS];
   logic [2*COORD_BITS-1:0] rd_data_ff;

   logic [3:0]           state_ff, state_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [CountBits-1:0] idx_ff, idx_in;
   logic [SumBits-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                 ovf_ff, ovf_in;
   logic [LimitBits-1:0] limit_ff;
   logic [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [63:0]          acc_ff, acc_in;
   logic [RadiusBits+2:0] rad_ff, rad_in;
   logic [63:0]          dist_ff, dist_in;
   logic                 flag_ff, flag_in;
   logic                 wr_en;
   logic [AddrBits-1:0]  rd_addr;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   alu_req_type          alu_ctl;
   alu_rsp_type          alu_sts;
   logic signed [COORD_BITS+1:0] dx, dy;
   logic [2*COORD_BITS+3:0] d2;
   logic [63:0]          diff;

   ccft_alu u_alu (.clock(clock), .reset(reset), .ctl(alu_ctl), .sts(alu_sts));

   assign req.ready = (state_ff == StIdle);
   assign wr_en = req.valid && req.ready && (count_ff < CountMax);
   assign rd_addr = idx_ff[AddrBits-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[AddrBits-1:0]] <=
            {req.payload.point_y[COORD_BITS-1:0], req.payload.point_x[COORD_BITS-1:0]};
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign dx = $signed({2'b00, cx_ff}) - $signed({2'b00, rd_data_ff[COORD_BITS-1:0]});
   assign dy = $signed({2'b00, cy_ff}) - $signed({2'b00, rd_data_ff[2*COORD_BITS-1:COORD_BITS]});
   assign d2 = (2*COORD_BITS+4)'(dx * dx) + (2*COORD_BITS+4)'(dy * dy);
   assign diff = (dist_ff >= 64'(rad_ff)) ? dist_ff - 64'(rad_ff) : 64'(rad_ff) - dist_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      ovf_in   = ovf_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      acc_in   = acc_ff;
      rad_in   = rad_ff;
      dist_in  = dist_ff;
      flag_in  = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in   = rsp_ff;
      alu_ctl  = '0;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (req.valid) begin
               if (count_ff < CountMax) begin
                  count_in = count_ff + 1'b1;
                  sum_x_in = sum_x_ff + SumBits'(req.payload.point_x[COORD_BITS-1:0]);
                  sum_y_in = sum_y_ff + SumBits'(req.payload.point_y[COORD_BITS-1:0]);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req.payload.last_point) begin
                  state_in = StDivX;
                  alu_ctl.start = 1'b1;
                  alu_ctl.op  = OpDiv;
                  alu_ctl.num = 64'(sum_x_in);
                  alu_ctl.den = 32'(count_in);
               end else begin
                  state_in = StWait;
               end
            end
         end
         StWait: state_in = StIdle;
         StDivX: if (alu_sts.done) begin
            cx_in = alu_sts.result[COORD_BITS-1:0];
            alu_ctl.start = 1'b1;
            alu_ctl.op  = OpDiv;
            alu_ctl.num = 64'(sum_y_ff);
            alu_ctl.den = 32'(count_ff);
            state_in = StDivY;
         end
         StDivY: if (alu_sts.done) begin
            cy_in  = alu_sts.result[COORD_BITS-1:0];
            idx_in = '0;
            acc_in = '0;
            state_in = StRead1;
         end
         StRead1: state_in = StRead1b;
         StRead1b: state_in = StAcc1;
         StAcc1: begin
            acc_in = acc_ff + 64'(d2);
            idx_in = idx_ff + 1'b1;
            if (idx_in == count_ff) begin
               state_in = StMeanSq;
               alu_ctl.start = 1'b1;
               alu_ctl.op  = OpDiv;
               alu_ctl.num = {acc_in[47:0], 16'd0};
               alu_ctl.den = 32'(count_ff);
            end else begin
               state_in = StRead1b;
            end
         end
         StMeanSq: if (alu_sts.done) begin
            alu_ctl.start = 1'b1;
            alu_ctl.op  = OpSqrt;
            alu_ctl.num = alu_sts.result;
            state_in = StRadius;
         end
         StRadius: if (alu_sts.done) begin
            rad_in = (RadiusBits+3)'(alu_sts.result);
            idx_in = '0;
            acc_in = '0;
            state_in = StRead2;
         end
         StRead2: state_in = StRead2b;
         StRead2b: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op  = OpSqrt;
            alu_ctl.num = 64'({d2, 16'd0});
            state_in = StDist;
         end
         StDist: if (alu_sts.done) begin
            dist_in  = alu_sts.result;
            state_in = StSq;
         end
         StSq: begin
            dist_in = 64'(diff[31:0] * diff[31:0]);
            state_in = StDev;
         end
         StDev: begin
            acc_in = acc_ff + dist_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_in == count_ff) begin
               state_in = StMeanDev;
               alu_ctl.start = 1'b1;
               alu_ctl.op  = OpDiv;
               alu_ctl.num = acc_in;
               alu_ctl.den = 32'(count_ff);
            end else begin
               state_in = StRead2;
            end
         end
         StMeanDev: if (alu_sts.done) begin
            flag_in  = !ovf_ff && (alu_sts.result < 64'(limit_ff));
            state_in = StOut;
         end
         StOut: if (!rsp_valid_ff || rsp.ready) begin
            rsp_valid_in = 1'b1;
            rsp_in.center_x = FieldBits'(cx_ff);
            rsp_in.center_y = FieldBits'(cy_ff);
            rsp_in.radius_fixed = rad_ff[RadiusBits-1:0];
            rsp_in.is_circle = flag_ff;
            rsp_in.point_overflow = ovf_ff;
            count_in = '0;
            sum_x_in = '0;
            sum_y_in = '0;
            ovf_in   = 1'b0;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         ovf_ff   <= 1'b0;
         limit_ff <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         ovf_ff   <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) limit_ff <= csr_write_data;
      end
      idx_ff  <= idx_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      dist_ff <= dist_in;
      flag_ff <= flag_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

/* design/ccft_alu.sv */
module ccft_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  ccft_pkg::alu_req_type ctl,
   output ccft_pkg::alu_rsp_type sts
);
   import ccft_pkg::*;

   // Restoring division, one quotient bit per cycle, or digit-by-digit
   // square root, one root bit per cycle; both share the one subtractor.
   logic        busy_ff, busy_in;
   logic        op_ff, op_in;
   logic [6:0]  step_ff, step_in;
   logic [63:0] num_ff, num_in;
   logic [65:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [31:0] den_ff, den_in;
   logic        done_ff, done_in;
   logic [65:0] trial;
   logic [65:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      rem_sh  = '0;
      trial   = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         num_in  = ctl.num;
         den_in  = ctl.den;
         rem_in  = '0;
         res_in  = '0;
         step_in = (ctl.op == OpSqrt) ? 7'd32 : 7'd64;
      end else if (busy_ff) begin
         if (op_ff == OpSqrt) begin
            rem_sh = {rem_ff[63:0], num_ff[63:62]};
            trial  = {res_ff[63:0], 2'b01};
            num_in = {num_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               res_in = {res_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               res_in = {res_ff[62:0], 1'b0};
            end
         end else begin
            rem_sh = {rem_ff[64:0], num_ff[63]};
            trial  = {34'd0, den_ff};
            num_in = {num_ff[62:0], 1'b0};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               res_in = {res_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               res_in = {res_ff[62:0], 1'b0};
            end
         end
         step_in = step_ff - 7'd1;
         if (step_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      den_ff  <= den_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = res_ff;
endmodule
